>>> design/grid_height_bilinear_lookup_top_defines.svh
// Assertion macros for the grid height lookup modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GRID_HEIGHT_BILINEAR_LOOKUP_TOP_DEFINES_SVH
`define GRID_HEIGHT_BILINEAR_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GHBL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid height lookup: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GHBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid height lookup: next-cycle check failed");

`endif

>>> design/ghbl_pkg.sv
// Shared constants, types and helpers of the grid height lookup block.
// Depends on nothing; used by the interfaces, the top, ghbl_front and ghbl_back.
package ghbl_pkg;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int FRAC_BITS   = 16;
  localparam int CELLS       = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int COL_W       = 6;
  localparam int ROW_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int HEIGHT_W    = 24;
  localparam int POS_W       = 32;
  localparam int INV_W       = 32;
  localparam int CNT_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COORD_W     = SIZE_W + FRAC_BITS;
  localparam int FRAC1_W     = FRAC_BITS + 1;
  localparam int SCALE_SHIFT = INV_W - FRAC_BITS;
  localparam int WORD_W      = HEIGHT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_INV_X     = 3'd2,
    CFG_INV_Y     = 3'd3,
    CFG_COLUMNS   = 3'd4,
    CFG_ROWS      = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STORE_RD,
    ST_STORE_WR,
    ST_MUL_X,
    ST_MUL_Y,
    ST_CLAMP_Y,
    ST_READ,
    ST_BLEND_A,
    ST_BLEND_B,
    ST_BLEND_Q,
    ST_SUM,
    ST_DONE
  } state_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic                       is_query;
    logic                       in_grid;
    logic [COL_W-1:0]           col;
    logic [ROW_W-1:0]           row;
    logic signed [HEIGHT_W-1:0] height;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
  } item_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [INV_W-1:0]        inv_x;
    logic [INV_W-1:0]        inv_y;
    logic [SIZE_W-1:0]       cols;
    logic [SIZE_W-1:0]       rows;
    logic                    resize;
  } cfg_t;

  // Control between the queue and the execution side.
  typedef struct packed {
    logic pop;
    logic clearing;
  } q_ctl_t;

  // Grid size limited to the storage size.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n,
                                                 input logic [SIZE_W-1:0] lim);
    return (n > lim) ? lim : n;
  endfunction

endpackage

>>> design/ghbl_ifs.sv
// Handshake interfaces for the request and result channels.
// Depends on ghbl_pkg for field widths.
interface ghbl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [ghbl_pkg::COL_W-1:0]           col;
  logic [ghbl_pkg::ROW_W-1:0]           row;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] height_in;
  logic signed [ghbl_pkg::POS_W-1:0]    pos_x;
  logic signed [ghbl_pkg::POS_W-1:0]    pos_y;

  modport source (output valid, func, col, row, height_in, pos_x, pos_y, input ready);
  modport sink (input valid, func, col, row, height_in, pos_x, pos_y, output ready);
endinterface

interface ghbl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] height_out;
  logic                                 stored;
  logic                                 complete;

  modport source (output valid, height_out, stored, complete, input ready);
  modport sink (input valid, height_out, stored, complete, output ready);
endinterface

>>> design/grid_height_bilinear_lookup_top.sv
// Grid height lookup: a stored grid of probe heights with bilinear queries.
//
// Requests arrive on in_if (valid/ready). func 0 stores height_in at (col,row);
// func 1 queries the height at (pos_x,pos_y) in micrometres. Each request gives
// exactly one result on out_if (valid/ready): height_out, stored and complete.
// Configuration registers are written through cfg_we/cfg_idx/cfg_data.
// A store reads its cell and then writes it; a query reads four cells through
// the single read port of the height RAM and runs the chain of scaling and
// blend multiplies; stores outside the grid and queries on a degenerate grid
// go straight to the result. One request is executed at a time.
// A two-entry queue keeps accepting requests while a result waits for out_if.ready,
// so a stalled receiver holds the result and backs up the queue, then in_if.ready.
// After reset, and after any write to columns or rows, the store is cleared in
// a sweep over all 4096 cells, one cell per cycle, during which in_if.ready is low.
// Depends on ghbl_pkg, ghbl_ifs, ghbl_front and ghbl_back.
module grid_height_bilinear_lookup_top (
  input  logic                              clk,
  input  logic                              rst_n,
  ghbl_in_if.sink                           in_if,
  ghbl_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [ghbl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ghbl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic signed [ghbl_pkg::POS_W-1:0] origin_x_r, origin_y_r;
  logic [ghbl_pkg::INV_W-1:0]        inv_x_r, inv_y_r;
  logic [ghbl_pkg::SIZE_W-1:0]       cols_r, rows_r;
  ghbl_pkg::cfg_t                    cfg;
  ghbl_pkg::q_ctl_t                  ctl;
  logic                              q_valid;
  ghbl_pkg::item_t                   q_item;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      inv_x_r    <= ghbl_pkg::INV_W'(429497);
      inv_y_r    <= ghbl_pkg::INV_W'(429497);
      cols_r     <= ghbl_pkg::SIZE_W'(2);
      rows_r     <= ghbl_pkg::SIZE_W'(2);
    end else if (cfg_we) begin
      unique case (ghbl_pkg::cfg_idx_t'(cfg_idx))
        ghbl_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        ghbl_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        ghbl_pkg::CFG_INV_X:    inv_x_r    <= cfg_data;
        ghbl_pkg::CFG_INV_Y:    inv_y_r    <= cfg_data;
        ghbl_pkg::CFG_COLUMNS:  cols_r     <= cfg_data[ghbl_pkg::SIZE_W-1:0];
        ghbl_pkg::CFG_ROWS:     rows_r     <= cfg_data[ghbl_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration view for the datapath; a size write triggers the clear.
  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.inv_x    = inv_x_r;
    cfg.inv_y    = inv_y_r;
    cfg.cols     = cols_r;
    cfg.rows     = rows_r;
    cfg.resize   = cfg_we && rst_n &&
                   ((cfg_idx == ghbl_pkg::CFG_COLUMNS) || (cfg_idx == ghbl_pkg::CFG_ROWS));
  end

  ghbl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg     (cfg),
    .ctl     (ctl),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  ghbl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .ctl     (ctl),
    .out_if  (out_if)
  );

endmodule

>>> design/ghbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ghbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ghbl_front.sv
// Request side: accepts requests, classifies them and queues up to two of them.
// Depends on ghbl_pkg and ghbl_ifs.
module ghbl_front (
  input  logic                clk,
  input  logic                rst_n,
  ghbl_in_if.sink             in_if,
  input  ghbl_pkg::cfg_t      cfg,
  input  ghbl_pkg::q_ctl_t    ctl,
  output logic                q_valid,
  output ghbl_pkg::item_t     q_item
);

  ghbl_pkg::item_t entries_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  ghbl_pkg::item_t cls;
  logic [ghbl_pkg::SIZE_W-1:0] eff_c, eff_r;

  // Requests are refused while the store is being cleared.
  assign in_if.ready = (cnt_r != 2'd2) && !ctl.clearing;
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = entries_r[rd_ptr_r];

  // Classify: query or store, and whether a store lands inside the grid.
  always_comb begin
    eff_c        = ghbl_pkg::eff_size(cfg.cols, ghbl_pkg::SIZE_W'(ghbl_pkg::MAX_COLS));
    eff_r        = ghbl_pkg::eff_size(cfg.rows, ghbl_pkg::SIZE_W'(ghbl_pkg::MAX_ROWS));
    cls.is_query = (in_if.func == ghbl_pkg::FUNC_QUERY);
    cls.in_grid  = ({1'b0, in_if.col} < eff_c) && ({1'b0, in_if.row} < eff_r);
    cls.col      = in_if.col;
    cls.row      = in_if.row;
    cls.height   = in_if.height_in;
    cls.pos_x    = in_if.pos_x;
    cls.pos_y    = in_if.pos_y;
  end

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, ctl.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> design/ghbl_back.sv
// Execution side: height store, position scaling, bilinear blend, result register.
// Depends on ghbl_pkg, ghbl_ifs, ghbl_ram and the assertion macro header.
`include "grid_height_bilinear_lookup_top_defines.svh"

module ghbl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ghbl_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ghbl_pkg::item_t     q_item,
  output ghbl_pkg::q_ctl_t    ctl,
  ghbl_out_if.source          out_if
);

  localparam int AB_W  = ghbl_pkg::HEIGHT_W + ghbl_pkg::FRAC_BITS + 2;
  localparam int BP_W  = ghbl_pkg::HEIGHT_W + 1 + ghbl_pkg::FRAC1_W + 1;
  localparam int Q_W   = AB_W + 1 + ghbl_pkg::FRAC1_W + 1;
  localparam int SUM_W = Q_W + 1;
  localparam int MUL_W = 2 * ghbl_pkg::POS_W;

  ghbl_pkg::state_t state_r, state_nxt;
  ghbl_pkg::item_t  cur_r;

  logic [ghbl_pkg::ADDR_W-1:0]        clr_cnt_r;
  logic [2:0]                         rd_cnt_r;
  logic [ghbl_pkg::CNT_W-1:0]         count_r;
  logic [MUL_W-1:0]                   prod_r;
  logic [ghbl_pkg::COORD_W-1:0]       fx_r, fy_r;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] cells_r [4];
  logic signed [AB_W-1:0]             a_r, b_r;
  logic signed [Q_W-1:0]              q_r;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] res_r;
  logic                               stored_r;
  logic                               out_valid_r;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] out_height_r;
  logic                               out_stored_r;
  logic                               out_complete_r;

  logic [ghbl_pkg::SIZE_W-1:0] eff_c, eff_r;
  logic                        grid_ok;
  logic                        complete_now;

  // RAM ports.
  logic                         ram_we;
  logic [ghbl_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ghbl_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;
  logic                         load_out;

  // Scaling datapath.
  logic [ghbl_pkg::POS_W:0]     off;
  logic [ghbl_pkg::INV_W-1:0]   mul_inv;
  logic                         off_pos;
  logic [MUL_W-1:0]             mul_p;

  // Cell selection.
  logic [ghbl_pkg::SIZE_W-1:0]  ix, iy, lim_x, lim_y, ax, ay;
  logic [ghbl_pkg::FRAC1_W-1:0] tx, ty;
  logic [1:0]                   cap_idx;

  // Blend datapath.
  logic signed [ghbl_pkg::HEIGHT_W:0]   blend_d;
  logic signed [ghbl_pkg::HEIGHT_W-1:0] blend_base;
  logic signed [BP_W-1:0]               blend_p;
  logic signed [AB_W-1:0]               blend_v;
  logic signed [AB_W:0]                 ab_diff;
  logic signed [SUM_W-1:0]              sum_v;

  // Grid size and completion status.
  assign eff_c   = ghbl_pkg::eff_size(cfg.cols, ghbl_pkg::SIZE_W'(ghbl_pkg::MAX_COLS));
  assign eff_r   = ghbl_pkg::eff_size(cfg.rows, ghbl_pkg::SIZE_W'(ghbl_pkg::MAX_ROWS));
  assign grid_ok = (eff_c >= ghbl_pkg::SIZE_W'(2)) && (eff_r >= ghbl_pkg::SIZE_W'(2));
  assign complete_now = grid_ok &&
    (count_r == ghbl_pkg::CNT_W'((2 * ghbl_pkg::SIZE_W)'(eff_c) *
                                 (2 * ghbl_pkg::SIZE_W)'(eff_r)));

  // Shared multiplier: offset from origin times reciprocal spacing.
  always_comb begin
    if (state_r == ghbl_pkg::ST_MUL_X) begin
      off     = {cur_r.pos_x[ghbl_pkg::POS_W-1], cur_r.pos_x} -
                {cfg.origin_x[ghbl_pkg::POS_W-1], cfg.origin_x};
      mul_inv = cfg.inv_x;
    end else begin
      off     = {cur_r.pos_y[ghbl_pkg::POS_W-1], cur_r.pos_y} -
                {cfg.origin_y[ghbl_pkg::POS_W-1], cfg.origin_y};
      mul_inv = cfg.inv_y;
    end
    off_pos = !off[ghbl_pkg::POS_W] && (off != '0);
    mul_p   = off_pos ? (MUL_W'(off[ghbl_pkg::POS_W-1:0]) * MUL_W'(mul_inv)) : '0;
  end

  // Drop the extra fraction bits and clamp to the last grid point.
  function automatic logic [ghbl_pkg::COORD_W-1:0] clamp_coord(
      input logic [MUL_W-1:0] p, input logic [ghbl_pkg::SIZE_W-1:0] n);
    logic [MUL_W-1:0] q;
    logic [MUL_W-1:0] top;
    q   = p >> ghbl_pkg::SCALE_SHIFT;
    top = MUL_W'(n - ghbl_pkg::SIZE_W'(1)) << ghbl_pkg::FRAC_BITS;
    return (q > top) ? top[ghbl_pkg::COORD_W-1:0] : q[ghbl_pkg::COORD_W-1:0];
  endfunction

  // Base cell kept no higher than two below the grid size; fractions may reach one.
  always_comb begin
    lim_x   = eff_c - ghbl_pkg::SIZE_W'(2);
    lim_y   = eff_r - ghbl_pkg::SIZE_W'(2);
    ix      = (fx_r[ghbl_pkg::COORD_W-1:ghbl_pkg::FRAC_BITS] > lim_x) ?
              lim_x : fx_r[ghbl_pkg::COORD_W-1:ghbl_pkg::FRAC_BITS];
    iy      = (fy_r[ghbl_pkg::COORD_W-1:ghbl_pkg::FRAC_BITS] > lim_y) ?
              lim_y : fy_r[ghbl_pkg::COORD_W-1:ghbl_pkg::FRAC_BITS];
    tx      = ghbl_pkg::FRAC1_W'(fx_r - (ghbl_pkg::COORD_W'(ix) << ghbl_pkg::FRAC_BITS));
    ty      = ghbl_pkg::FRAC1_W'(fy_r - (ghbl_pkg::COORD_W'(iy) << ghbl_pkg::FRAC_BITS));
    ax      = ix + ghbl_pkg::SIZE_W'(rd_cnt_r[0]);
    ay      = iy + ghbl_pkg::SIZE_W'(rd_cnt_r[1]);
    cap_idx = 2'(rd_cnt_r - 3'd1);
  end

  // One row of the blend: base * one + (next - base) * tx.
  always_comb begin
    if (state_r == ghbl_pkg::ST_BLEND_A) begin
      blend_base = cells_r[0];
      blend_d    = (ghbl_pkg::HEIGHT_W+1)'(cells_r[1]) - (ghbl_pkg::HEIGHT_W+1)'(cells_r[0]);
    end else begin
      blend_base = cells_r[2];
      blend_d    = (ghbl_pkg::HEIGHT_W+1)'(cells_r[3]) - (ghbl_pkg::HEIGHT_W+1)'(cells_r[2]);
    end
    blend_p = blend_d * $signed({1'b0, tx});
    blend_v = (AB_W'(blend_base) <<< ghbl_pkg::FRAC_BITS) + AB_W'(blend_p);
    ab_diff = (AB_W+1)'(b_r) - (AB_W+1)'(a_r);
    sum_v   = (SUM_W'(a_r) <<< ghbl_pkg::FRAC_BITS) + SUM_W'(q_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ghbl_pkg::ST_CLEAR: begin
        if (clr_cnt_r == ghbl_pkg::ADDR_W'(ghbl_pkg::CELLS - 1)) begin
          state_nxt = ghbl_pkg::ST_IDLE;
        end
      end
      ghbl_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.is_query) begin
            state_nxt = grid_ok ? ghbl_pkg::ST_MUL_X : ghbl_pkg::ST_DONE;
          end else begin
            state_nxt = q_item.in_grid ? ghbl_pkg::ST_STORE_RD : ghbl_pkg::ST_DONE;
          end
        end
      end
      ghbl_pkg::ST_STORE_RD: state_nxt = ghbl_pkg::ST_STORE_WR;
      ghbl_pkg::ST_STORE_WR: state_nxt = ghbl_pkg::ST_DONE;
      ghbl_pkg::ST_MUL_X:    state_nxt = ghbl_pkg::ST_MUL_Y;
      ghbl_pkg::ST_MUL_Y:    state_nxt = ghbl_pkg::ST_CLAMP_Y;
      ghbl_pkg::ST_CLAMP_Y:  state_nxt = ghbl_pkg::ST_READ;
      ghbl_pkg::ST_READ: begin
        if (rd_cnt_r == 3'd4) begin
          state_nxt = ghbl_pkg::ST_BLEND_A;
        end
      end
      ghbl_pkg::ST_BLEND_A:  state_nxt = ghbl_pkg::ST_BLEND_B;
      ghbl_pkg::ST_BLEND_B:  state_nxt = ghbl_pkg::ST_BLEND_Q;
      ghbl_pkg::ST_BLEND_Q:  state_nxt = ghbl_pkg::ST_SUM;
      ghbl_pkg::ST_SUM:      state_nxt = ghbl_pkg::ST_DONE;
      ghbl_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = ghbl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ghbl_pkg::ST_CLEAR;
    endcase
    // A resize restarts the clearing sweep.
    if (cfg.resize) begin
      state_nxt = ghbl_pkg::ST_CLEAR;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    ctl.pop      = (state_r == ghbl_pkg::ST_IDLE) && q_valid && !cfg.resize;
    ctl.clearing = (state_r == ghbl_pkg::ST_CLEAR);
    ram_we       = (state_r == ghbl_pkg::ST_CLEAR) || (state_r == ghbl_pkg::ST_STORE_WR);
    if (state_r == ghbl_pkg::ST_CLEAR) begin
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_waddr = ghbl_pkg::ADDR_W'(cur_r.row) * ghbl_pkg::ADDR_W'(ghbl_pkg::MAX_COLS) +
                  ghbl_pkg::ADDR_W'(cur_r.col);
      ram_wdata = {1'b1, cur_r.height};
    end
    if (state_r == ghbl_pkg::ST_READ) begin
      ram_raddr = ghbl_pkg::ADDR_W'(ay) * ghbl_pkg::ADDR_W'(ghbl_pkg::MAX_COLS) +
                  ghbl_pkg::ADDR_W'(ax);
    end else begin
      ram_raddr = ghbl_pkg::ADDR_W'(cur_r.row) * ghbl_pkg::ADDR_W'(ghbl_pkg::MAX_COLS) +
                  ghbl_pkg::ADDR_W'(cur_r.col);
    end
    load_out = (state_r == ghbl_pkg::ST_DONE) && (!out_valid_r || out_if.ready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghbl_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.resize) begin
        clr_cnt_r <= '0;
        count_r   <= '0;
      end else begin
        if (state_r == ghbl_pkg::ST_CLEAR) begin
          clr_cnt_r <= clr_cnt_r + ghbl_pkg::ADDR_W'(1);
        end
        if ((state_r == ghbl_pkg::ST_STORE_WR) && !ram_rdata[ghbl_pkg::WORD_W-1]) begin
          count_r <= count_r + ghbl_pkg::CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_r    <= q_item;
      res_r    <= '0;
      stored_r <= 1'b0;
    end
    if (state_r == ghbl_pkg::ST_STORE_WR) begin
      stored_r <= 1'b1;
    end
    if ((state_r == ghbl_pkg::ST_MUL_X) || (state_r == ghbl_pkg::ST_MUL_Y)) begin
      prod_r <= mul_p;
    end
    if (state_r == ghbl_pkg::ST_MUL_Y) begin
      fx_r <= clamp_coord(prod_r, eff_c);
    end
    if (state_r == ghbl_pkg::ST_CLAMP_Y) begin
      fy_r     <= clamp_coord(prod_r, eff_r);
      rd_cnt_r <= 3'd0;
    end
    if (state_r == ghbl_pkg::ST_READ) begin
      rd_cnt_r <= rd_cnt_r + 3'd1;
      if (rd_cnt_r != 3'd0) begin
        cells_r[cap_idx] <= ram_rdata[ghbl_pkg::HEIGHT_W-1:0];
      end
    end
    if (state_r == ghbl_pkg::ST_BLEND_A) begin
      a_r <= blend_v;
    end
    if (state_r == ghbl_pkg::ST_BLEND_B) begin
      b_r <= blend_v;
    end
    if (state_r == ghbl_pkg::ST_BLEND_Q) begin
      q_r <= ab_diff * $signed({1'b0, ty});
    end
    if (state_r == ghbl_pkg::ST_SUM) begin
      res_r <= sum_v[2*ghbl_pkg::FRAC_BITS +: ghbl_pkg::HEIGHT_W];
    end
    if (load_out) begin
      out_height_r   <= res_r;
      out_stored_r   <= stored_r;
      out_complete_r <= complete_now;
    end
  end

  ghbl_ram #(
    .WIDTH (ghbl_pkg::WORD_W),
    .DEPTH (ghbl_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.height_out = out_height_r;
  assign out_if.stored     = out_stored_r;
  assign out_if.complete   = out_complete_r;

  // The store is written only by the clearing sweep or a store request.
`GHBL_ASSERT_IMPL(a_we_source, clk, rst_n, ram_we, (state_r == ghbl_pkg::ST_CLEAR) || (state_r == ghbl_pkg::ST_STORE_WR))
  // The written-cell count never passes the number of cells.
`GHBL_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= ghbl_pkg::CNT_W'(ghbl_pkg::CELLS))
  // Taking a request always leaves the idle state.
`GHBL_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, ctl.pop, state_r != ghbl_pkg::ST_IDLE)

endmodule
